FILE: rtl/ppsm_pkg.sv
// Shared types and constants of the pulse period speed meter.
// Used by the controller, the datapath, the divider and the top level.
package ppsm_pkg;

	localparam int unsigned QUO_W = 20;
	localparam logic [QUO_W-1:0] SPEED_NUM = 20'd1000000;
	localparam logic [QUO_W-1:0] STABLE_LIMIT = 20'd999;
	localparam logic [QUO_W-1:0] FILTER_LIMIT = 20'd1200;
	localparam logic [31:0] STARTUP_MS = 32'd2000;
	localparam logic [31:0] STALE_MS = 32'd1000;
	localparam logic [3:0] STABLE_SKIP = 4'd10;
	localparam int unsigned AVG_SHIFT = 3;
	localparam int unsigned SPEED_W = 11;

	typedef enum logic [0:0] {
		CFG_SPEED_MODE = 1'b0,
		CFG_DEBOUNCE   = 1'b1
	} cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic edge_upd;
		logic accum;
		logic div_init;
		logic div_src_avg;
		logic div_step;
		logic insert;
		logic med_step;
		logic commit;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_rise;
		logic stable_mode;
		logic skip_stable;
		logic held_zero;
		logic avg_tick;
		logic avg_zero;
		logic div_last;
		logic med_last;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/ppsm_div.sv
// Restoring divider: the speed numerator divided by a 32-bit divisor,
// one quotient bit per cycle while step is high. Depends on ppsm_pkg.
module ppsm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          init,
	input  logic                          step,
	input  logic [31:0]                   divisor,
	output logic [ppsm_pkg::QUO_W-1:0]    quotient,
	output logic                          last
);

	localparam int unsigned QW = ppsm_pkg::QUO_W;
	localparam int unsigned CW = $clog2(QW);

	logic [CW-1:0] cnt_q;
	logic [31:0]   dvs_q;
	logic [QW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [QW:0]   trial;
	logic          ge;

	// The numerator is shifted out of the quotient register as quotient bits enter.
	assign trial = {rem_q, quo_q[QW-1]};
	assign ge    = {{(31-QW){1'b0}}, trial} >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (init) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (init) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= ppsm_pkg::SPEED_NUM;
		end else if (step) begin
			rem_q <= ge ? QW'(trial - dvs_q[QW:0]) : trial[QW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign last     = (cnt_q == CW'(QW - 1));

endmodule

FILE: rtl/ppsm_dp.sv
// Datapath of the pulse period speed meter: edge timing state, averaging,
// divider, median window, configuration and output registers. Depends on ppsm_pkg, ppsm_div.
module ppsm_dp #(
	parameter int unsigned WINDOW_SIZE = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ppsm_pkg::cmd_t    cmd,
	output ppsm_pkg::status_t status,
	input  logic [63:0]       in_tdata,
	input  logic              in_level,
	output logic              out_tvalid,
	input  logic              out_tready,
	output logic [15:0]       out_tdata,
	output logic              out_fresh,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int unsigned QW = ppsm_pkg::QUO_W;
	localparam int unsigned IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int unsigned NW = $clog2(WINDOW_SIZE + 1);
	localparam int unsigned SW = ppsm_pkg::SPEED_W;

	logic        mode_q;
	logic [15:0] deb_q;

	logic        lvl_q;
	logic [31:0] t_q;
	logic [31:0] now_q;

	logic [31:0] rise_q;
	logic [31:0] fall_q;
	logic [31:0] held_q;
	logic [7:0]  ec_q;
	logic [3:0]  c10_q;
	logic [31:0] sum_q;
	logic [31-ppsm_pkg::AVG_SHIFT:0] avg_q;
	logic [QW-1:0] win_q [WINDOW_SIZE];
	logic [IW-1:0] pos_q;
	logic [IW-1:0] cand_q;
	logic [QW-1:0] med_q;
	logic [SW-1:0] shown_q;
	logic [31:0] last_upd_q;
	logic        fresh_q;

	logic [31:0]   sum_next;
	logic [31:0]   divisor;
	logic [QW-1:0] quotient;
	logic          div_last;
	logic [QW-1:0] cur;
	logic [NW-1:0] rank;
	logic [QW-1:0] spd;
	logic [QW-1:0] lim;
	logic          live;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			deb_q  <= 16'd200;
		end else if (cfg_valid) begin
			case (cfg_index)
				ppsm_pkg::CFG_SPEED_MODE: mode_q <= cfg_data[0];
				ppsm_pkg::CFG_DEBOUNCE:   deb_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lvl_q <= in_level;
			t_q   <= in_tdata[31:0];
			now_q <= in_tdata[63:32];
		end
	end

	assign sum_next = sum_q + held_q;
	assign divisor  = cmd.div_src_avg ? {{ppsm_pkg::AVG_SHIFT{1'b0}}, avg_q} : held_q;

	ppsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.init     (cmd.div_init),
		.step     (cmd.div_step),
		.divisor  (divisor),
		.quotient (quotient),
		.last     (div_last)
	);

	// Rank of the current candidate; ties are broken by position so each rank is unique.
	assign cur = win_q[cand_q];
	always_comb begin
		rank = '0;
		for (int j = 0; j < WINDOW_SIZE; j++) begin
			if (win_q[j] < cur || (win_q[j] == cur && IW'(j) < cand_q)) begin
				rank = rank + 1'b1;
			end
		end
	end

	assign spd  = mode_q ? quotient : med_q;
	assign lim  = mode_q ? ppsm_pkg::STABLE_LIMIT : ppsm_pkg::FILTER_LIMIT;
	assign live = (now_q > ppsm_pkg::STARTUP_MS) && ((now_q - last_upd_q) < ppsm_pkg::STALE_MS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q     <= '0;
			fall_q     <= '0;
			held_q     <= '0;
			ec_q       <= '0;
			c10_q      <= '0;
			sum_q      <= '0;
			pos_q      <= '0;
			shown_q    <= '0;
			last_upd_q <= '0;
			fresh_q    <= 1'b0;
			out_tvalid <= 1'b0;
			for (int i = 0; i < WINDOW_SIZE; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				fresh_q <= 1'b0;
			end
			if (cmd.edge_upd) begin
				if (lvl_q) begin
					if ((t_q - fall_q) > {16'b0, deb_q}) begin
						held_q <= t_q - rise_q;
					end
					rise_q <= t_q;
					ec_q   <= ec_q + 8'd1;
					// Tracks the edge count modulo ten, including the 8-bit wrap.
					if (ec_q == 8'hFF || c10_q == ppsm_pkg::STABLE_SKIP - 4'd1) begin
						c10_q <= '0;
					end else begin
						c10_q <= c10_q + 4'd1;
					end
				end else begin
					fall_q <= t_q;
				end
			end
			if (cmd.accum) begin
				sum_q <= (ec_q[ppsm_pkg::AVG_SHIFT-1:0] == '0) ? '0 : sum_next;
			end
			if (cmd.insert) begin
				win_q[pos_q] <= quotient;
				pos_q <= (pos_q == IW'(WINDOW_SIZE - 1)) ? '0 : pos_q + 1'b1;
			end
			if (cmd.commit && spd < lim) begin
				shown_q    <= spd[SW-1:0];
				last_upd_q <= now_q;
				fresh_q    <= 1'b1;
			end
			if (cmd.out_load) begin
				out_tvalid <= 1'b1;
			end else if (out_tready) begin
				out_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accum && ec_q[ppsm_pkg::AVG_SHIFT-1:0] == '0) begin
			avg_q <= sum_next[31:ppsm_pkg::AVG_SHIFT];
		end
		if (cmd.insert) begin
			cand_q <= '0;
		end else if (cmd.med_step) begin
			if (rank == NW'(WINDOW_SIZE / 2)) begin
				med_q <= cur;
			end
			cand_q <= cand_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_tdata <= {{(16-SW){1'b0}}, (live ? shown_q : {SW{1'b0}})};
			out_fresh <= fresh_q;
		end
	end

	assign status.is_rise     = lvl_q;
	assign status.stable_mode = mode_q;
	assign status.skip_stable = (c10_q == 4'd0);
	assign status.held_zero   = (held_q == '0);
	assign status.avg_tick    = (ec_q[ppsm_pkg::AVG_SHIFT-1:0] == '0);
	assign status.avg_zero    = (avg_q == '0);
	assign status.div_last    = div_last;
	assign status.med_last    = (cand_q == IW'(WINDOW_SIZE - 1));
	assign status.out_free    = !out_tvalid || out_tready;

`ifndef SYNTHESIS
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_tvalid)
		else $error("output not valid after load");
	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && spd < lim |=> fresh_q && last_upd_q == $past(now_q))
		else $error("accepted speed not recorded");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= IW'(WINDOW_SIZE - 1))
		else $error("window position out of range");
	a_fresh_rise: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && fresh_q |-> lvl_q)
		else $error("fresh result from a falling edge");
	a_startup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && !(now_q > ppsm_pkg::STARTUP_MS) |=> out_tdata == 16'd0)
		else $error("nonzero speed during start-up");
`endif

endmodule

FILE: rtl/ppsm_ctrl.sv
// Controller state machine of the pulse period speed meter.
// Sequences the datapath through commands. Depends on ppsm_pkg.
module ppsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ppsm_pkg::status_t status,
	output ppsm_pkg::cmd_t    cmd
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_EDGE   = 9'b000000010,
		S_DECIDE = 9'b000000100,
		S_AVG    = 9'b000001000,
		S_DIV    = 9'b000010000,
		S_INSERT = 9'b000100000,
		S_MEDIAN = 9'b001000000,
		S_COMMIT = 9'b010000000,
		S_FINISH = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_next;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = S_EDGE;
				end
			end
			S_EDGE: begin
				cmd.edge_upd = 1'b1;
				state_next   = S_DECIDE;
			end
			S_DECIDE: begin
				if (!status.is_rise) begin
					state_next = S_FINISH;
				end else if (status.stable_mode) begin
					if (!status.skip_stable && !status.held_zero) begin
						cmd.div_init = 1'b1;
						state_next   = S_DIV;
					end else begin
						state_next = S_FINISH;
					end
				end else begin
					cmd.accum  = 1'b1;
					state_next = status.avg_tick ? S_AVG : S_FINISH;
				end
			end
			S_AVG: begin
				if (!status.avg_zero) begin
					cmd.div_init    = 1'b1;
					cmd.div_src_avg = 1'b1;
					state_next      = S_DIV;
				end else begin
					state_next = S_FINISH;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_next = status.stable_mode ? S_COMMIT : S_INSERT;
				end
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				state_next = S_MEDIAN;
			end
			S_MEDIAN: begin
				cmd.med_step = 1'b1;
				if (status.med_last) begin
					state_next = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_next = S_FINISH;
			end
			S_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_next   = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

FILE: rtl/pulse_period_speed_meter.sv
// Pulse period speed meter: measures a pulse frequency from timestamped edges.
// Usage:
//   The input stream carries one edge per transfer: tuser holds the line level
//   after the edge, tdata the microsecond and millisecond timestamps. Every input
//   transfer yields exactly one output transfer with the speed in Hz and a flag
//   telling whether this edge accepted a new speed.
//   The block works on one edge at a time; the result turns valid in the same
//   cycle as the next edge can be taken. An edge takes longest when a speed is
//   computed; the cost is set by the bit-serial divider (one quotient bit per
//   cycle) and the median search, which ranks one window entry per cycle.
//   The result sits in an output register; input is taken again as soon as the
//   result is stored there, and a stalled receiver only holds the block once a
//   second result is ready for that register.
//   Configuration writes (index 0: speed_mode, index 1: debounce_us) are taken
//   every cycle and are meant to happen while no edge is in progress.
//   Reset clears the edge times, edge counts, sum and median window, sets stable mode and a
//   200 us debounce, and empties the output register.
// Depends on ppsm_pkg, ppsm_ctrl, ppsm_dp.
module pulse_period_speed_meter #(
	parameter int unsigned WINDOW_SIZE = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // time_us [31:0], time_ms [63:32]
	input  logic [0:0]  s_axis_tuser,   // edge_level [0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // speed_hz [10:0], zero [15:11]
	output logic [0:0]  m_axis_tuser,   // fresh [0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	ppsm_pkg::cmd_t    cmd;
	ppsm_pkg::status_t status;

	ppsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ppsm_dp #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_tdata   (s_axis_tdata),
		.in_level   (s_axis_tuser[0]),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_fresh  (m_axis_tuser[0]),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

endmodule
